@@ rtl/ppm_pkg.sv @@
// Package with shared types and constants of the path progress engine.
`default_nettype none
package ppm_pkg;
    localparam int MaxPoints = 1024;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = IdxW + 1;
    localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MinSpeedReset = 32'd655;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_ODOM   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE, S_APP_RD, S_APP_WAIT, S_APP_SQ, S_APP_ROOT, S_APP_WR,
        S_OD_SQ, S_OD_ROOT, S_SP_SQ, S_SP_ROOT,
        S_SC_RD, S_SC_WAIT, S_SC_CMP, S_CL_RD, S_CL_WAIT, S_DIV, S_DIV_RUN, S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [30:0] pos_x;
        logic [30:0] pos_y;
        logic [30:0] vel_x;
        logic [30:0] vel_y;
    } t_in;

    typedef struct packed {
        logic        metrics_valid;
        logic [47:0] plan_length;
        logic [47:0] travelled;
        logic [9:0]  closest_index;
        logic [47:0] remaining;
        logic [47:0] arrival_time;
        logic        arrival_valid;
    } t_out;

    // Iterative unit commands.
    typedef enum logic [1:0] {
        OP_SQRT = 2'd0,
        OP_DIV  = 2'd1
    } t_op;
endpackage
`default_nettype wire

@@ rtl/ppm_if.sv @@
// Valid/ready channel interface carrying one payload beat.
`default_nettype none
interface ppm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/ppm_iter.sv @@
// Shared iterative unit: 64-bit integer square root or 64/33 division, bit a cycle.
`default_nettype none
module ppm_iter import ppm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_op         i_op,
    input  wire logic [63:0] i_a,
    input  wire logic [32:0] i_b,
    output logic             o_busy,
    output logic [63:0]      o_res
);
    logic [63:0] r_n, r_res, r_bit;
    logic [32:0] r_d;
    logic [33:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    t_op         r_op;
    logic [63:0] w_t;
    logic [33:0] w_rs;

    assign w_t  = r_res + r_bit;
    assign w_rs = {r_rem[32:0], r_n[63]};
    assign o_busy = r_busy;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_op   <= i_op;
            r_n    <= i_a;
            r_d    <= i_b;
            r_res  <= '0;
            r_rem  <= '0;
            r_bit  <= 64'h4000_0000_0000_0000;
            r_cnt  <= 7'd0;
        end else if (r_busy) begin
            if (r_op == OP_SQRT) begin
                if (r_n >= w_t) begin
                    r_n   <= r_n - w_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_cnt == 7'd31) r_busy <= 1'b0;
            end else begin
                r_n <= r_n << 1;
                if (w_rs >= {1'b0, r_d}) begin
                    r_rem <= w_rs - {1'b0, r_d};
                    r_res <= {r_res[62:0], 1'b1};
                end else begin
                    r_rem <= w_rs;
                    r_res <= {r_res[62:0], 1'b0};
                end
                if (r_cnt == 7'd63) r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 7'd1;
        end
    end
endmodule
`default_nettype wire

@@ rtl/path_progress_metrics.sv @@
// Top level of the path progress engine: sequencer, plan memory and result register.
// Odometry gives one result beat per accepted request, after square roots of the step and
// the speed, a scan of the stored points (read, wait and compare each) and, if needed, a division;
// an empty plan skips scan and division. Ready stays high after a clear or unused mode; an append
// drops it until the point is written or, on a full plan, refused; odometry until its result leaves.
// Reset (synchronous, active low) empties the plan, clears sums and sets min_speed to 655.
`default_nettype none
module path_progress_metrics import ppm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    ppm_if.sink              in_ch,
    ppm_if.source            out_ch
);
    // Plan storage, one read and one write port, registered read data.
    // The plan memory has no reset; only entries below the point count are used.
    logic [31:0] mem_x [MaxPoints];
    logic [31:0] mem_y [MaxPoints];
    logic [47:0] mem_c [MaxPoints];
    logic [31:0] r_rx, r_ry;
    logic [47:0] r_rc;
    logic [IdxW-1:0] w_raddr;
    logic        w_we;

    t_state      r_state, n_state;
    t_in         r_in;
    logic [31:0] r_min_speed;
    logic [CntW-1:0] r_count;
    logic [47:0] r_total, r_dist;
    logic [31:0] r_last_x, r_last_y;
    logic        r_have;
    logic [CntW-1:0] r_idx;
    logic [IdxW-1:0] r_best;
    logic [63:0] r_best_d;
    logic [47:0] r_rem, r_speed;
    logic        r_out_v;
    t_out        r_out;

    logic        w_start;
    t_op         w_op;
    logic [63:0] w_a;
    logic        w_busy;
    logic [63:0] w_res;
    logic [63:0] w_d;

    // Squared distance on 32-bit differences; multipliers are 32x32 each.
    function automatic logic [63:0] sqd(input logic [31:0] ax, input logic [31:0] ay,
                                        input logic [31:0] bx, input logic [31:0] by);
        logic [32:0] dx, dy;
        logic [31:0] ux, uy;
        dx = {ax[31], ax} - {bx[31], bx};
        dy = {ay[31], ay} - {by[31], by};
        ux = dx[32] ? 32'(-dx) : dx[31:0];
        uy = dy[32] ? 32'(-dy) : dy[31:0];
        return 64'(ux) * 64'(ux) + 64'(uy) * 64'(uy);
    endfunction

    logic [31:0] w_px, w_py, w_vx, w_vy;
    logic [31:0] w_sx, w_sy, w_tx, w_ty;
    logic [48:0] w_sum;
    logic [47:0] w_total_next;
    assign w_px = {r_in.pos_x[30], r_in.pos_x};
    assign w_py = {r_in.pos_y[30], r_in.pos_y};
    assign w_vx = {r_in.vel_x[30], r_in.vel_x};
    assign w_vy = {r_in.vel_y[30], r_in.vel_y};
    // One squarer serves the segment, the step, the speed and the scan.
    assign w_d  = sqd(w_sx, w_sy, w_tx, w_ty);

    ppm_iter u_iter (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_op(w_op),
        .i_a(w_a), .i_b({1'b0, r_speed[31:0]}), .o_busy(w_busy), .o_res(w_res)
    );

    assign in_ch.ready = (r_state == S_IDLE) && !r_out_v;
    assign out_ch.valid = r_out_v;
    assign out_ch.data  = r_out;

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        w_op    = OP_SQRT;
        w_a     = '0;
        w_raddr = r_idx[IdxW-1:0];
        w_we    = 1'b0;
        w_sx    = r_rx;
        w_sy    = r_ry;
        w_tx    = w_px;
        w_ty    = w_py;
        unique case (r_state)
            S_IDLE: if (in_ch.valid && in_ch.ready) begin
                unique case (t_mode'(in_ch.data.mode))
                    MODE_APPEND: n_state = S_APP_RD;
                    MODE_ODOM:   n_state = S_OD_SQ;
                    MODE_CLEAR:  n_state = S_IDLE;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_APP_RD: begin
                w_raddr = r_idx[IdxW-1:0];
                if (r_count[CntW-1]) n_state = S_IDLE;
                else if (r_count == '0) n_state = S_APP_WR;
                else n_state = S_APP_WAIT;
            end
            S_APP_WAIT: n_state = S_APP_SQ;
            S_APP_SQ: begin
                w_start = 1'b1;
                w_a = w_d;
                n_state = S_APP_ROOT;
            end
            S_APP_ROOT: if (!w_busy) n_state = S_APP_WR;
            S_APP_WR: begin
                w_we = 1'b1;
                n_state = S_IDLE;
            end
            S_OD_SQ: begin
                w_start = 1'b1;
                w_sx = w_px;
                w_sy = w_py;
                w_tx = r_last_x;
                w_ty = r_last_y;
                w_a = w_d;
                n_state = S_OD_ROOT;
            end
            S_OD_ROOT: if (!w_busy) n_state = S_SP_SQ;
            S_SP_SQ: begin
                w_start = 1'b1;
                w_sx = w_vx;
                w_sy = w_vy;
                w_tx = 32'd0;
                w_ty = 32'd0;
                w_a = w_d;
                n_state = S_SP_ROOT;
            end
            S_SP_ROOT: if (!w_busy) n_state = (r_count == '0) ? S_OUT : S_SC_RD;
            S_SC_RD: n_state = S_SC_WAIT;
            S_SC_WAIT: n_state = S_SC_CMP;
            // The scan ends after the last stored point.
            S_SC_CMP: n_state = (r_idx == r_count - CntW'(1)) ? S_CL_RD : S_SC_RD;
            S_CL_RD: begin
                w_raddr = r_best;
                n_state = S_CL_WAIT;
            end
            S_CL_WAIT: n_state = S_DIV;
            S_DIV: begin
                if (r_speed > {16'd0, r_min_speed} && r_speed != '0) begin
                    w_start = 1'b1;
                    w_op = OP_DIV;
                    w_a = {r_rem, 16'd0};
                    n_state = S_DIV_RUN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV_RUN: if (!w_busy) n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // The first point adds no segment, so its cumulative length is the current total.
    assign w_total_next = (r_count != '0) ? (w_sum[48] ? Max48 : w_sum[47:0]) : r_total;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_x[r_count[IdxW-1:0]] <= w_px;
            mem_y[r_count[IdxW-1:0]] <= w_py;
            mem_c[r_count[IdxW-1:0]] <= w_total_next;
        end
        r_rx <= mem_x[w_raddr];
        r_ry <= mem_y[w_raddr];
        r_rc <= mem_c[w_raddr];
    end

    assign w_sum = {1'b0, (r_state == S_APP_WR) ? r_total : r_dist} + {1'b0, w_res[47:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min_speed <= MinSpeedReset;
            r_count     <= '0;
            r_total     <= '0;
            r_dist      <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_have      <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_min_speed <= i_cfg_wdata;
            if (out_ch.valid && out_ch.ready) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_ch.valid && in_ch.ready) begin
                    r_in <= in_ch.data;
                    r_idx <= r_count - CntW'(1);
                    if (t_mode'(in_ch.data.mode) == MODE_CLEAR) begin
                        r_count <= '0;
                        r_total <= '0;
                        r_dist  <= '0;
                    end
                end
                S_APP_WR: begin
                    r_total <= w_total_next;
                    r_count <= r_count + CntW'(1);
                end
                S_OD_ROOT: if (!w_busy) begin
                    if (r_have) r_dist <= w_sum[48] ? Max48 : w_sum[47:0];
                    r_last_x <= w_px;
                    r_last_y <= w_py;
                    r_have   <= 1'b1;
                    r_idx    <= '0;
                end
                S_SP_ROOT: if (!w_busy) begin
                    r_speed <= w_res[47:0];
                    r_out   <= '0;
                end
                S_SC_CMP: begin
                    if (r_idx == '0 || w_d < r_best_d) begin
                        r_best_d <= w_d;
                        r_best   <= r_idx[IdxW-1:0];
                    end
                    r_idx <= r_idx + CntW'(1);
                end
                S_CL_WAIT: r_rem <= (r_total >= r_rc) ? r_total - r_rc : '0;
                S_DIV_RUN: if (!w_busy) begin
                    r_out.arrival_time  <= (w_res > {16'd0, Max48}) ? Max48 : w_res[47:0];
                    r_out.arrival_valid <= 1'b1;
                end
                S_OUT: begin
                    r_out_v <= 1'b1;
                    if (r_count != '0) begin
                        r_out.metrics_valid <= 1'b1;
                        r_out.plan_length   <= r_total;
                        r_out.travelled     <= r_dist;
                        r_out.closest_index <= 10'(r_best);
                        r_out.remaining     <= r_rem;
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !out_ch.ready |=> r_out_v)
        else $error("result dropped while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxPoints))
        else $error("point count past capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> !w_busy)
        else $error("ready while unit busy");
endmodule
`default_nettype wire
